/* design/assert_macros.svh */
// assertion macros shared by the polygon area modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

/* design/ppa_pkg.sv */
// shared types and constants for the planar polygon area block
package ppa_pkg;

   localparam int NORM_W     = 16;
   localparam int AREA_W     = 49;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int SUM_W      = 64;
   localparam int ITER_STEPS = 32;
   localparam int STEP_W     = $clog2(ITER_STEPS);

   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_Z = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK          = 2'd0,
      STATUS_SHORT       = 2'd1,
      STATUS_ZERO_NORMAL = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      TERM_VERTEX,
      TERM_WRAP_FIRST,
      TERM_WRAP_SECOND
   } term_sel_type;

   typedef struct packed {
      logic         accept;
      term_sel_type term_sel;
      logic         load_term;
      logic         add_term;
      logic         start_root;
      logic         root_step;
      logic         start_div;
      logic         div_step;
      logic         mul_hi;
      logic         mul_lo;
      logic         finish;
      logic         load_out;
      logic         area_zero;
   } ppa_cmd_type;

   typedef struct packed {
      logic tally_lt2;
      logic d_zero;
   } ppa_stat_type;

endpackage

/* design/ppa_vertex_if.sv */
// vertex input channel
interface ppa_vertex_if #(parameter int COORD_WIDTH = 24);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] vertex_x;
   logic signed [COORD_WIDTH-1:0] vertex_y;
   logic signed [COORD_WIDTH-1:0] vertex_z;
   logic                          last_vertex;

   modport source (output valid, vertex_x, vertex_y, vertex_z, last_vertex, input ready);
   modport sink (input valid, vertex_x, vertex_y, vertex_z, last_vertex, output ready);
endinterface

/* design/ppa_area_if.sv */
// area result channel
interface ppa_area_if;
   logic        valid;
   logic        ready;
   logic [48:0] area;
   logic [1:0]  status;

   modport source (output valid, area, status, input ready);
   modport sink (input valid, area, status, output ready);
endinterface

/* design/ppa_csr_if.sv */
// register write channel
interface ppa_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* design/ppa_ctrl.sv */
// sequencer for vertex accumulation and the closing computation
module ppa_ctrl import ppa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_last,
   output logic         req_ready,
   input  logic         rsp_ready,
   output logic         rsp_valid,
   output status_type   rsp_status,
   output ppa_cmd_type  cmd,
   input  ppa_stat_type stat
);
`include "assert_macros.svh"

   typedef enum logic [3:0] {
      S_IDLE, S_ACC, S_CLOSE, S_WRAP1, S_WRAP2, S_ROOT, S_DIVST, S_DIV,
      S_MULHI, S_MULLO, S_FIN, S_LOAD
   } state_type;

   state_type         state_ff;
   logic [STEP_W-1:0] step_ff;
   logic              last_ff;
   logic              short_ff;
   logic              rsp_valid_ff;
   status_type        status_ff;
   status_type        rsp_status_ff;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign req_ready  = (state_ff == S_IDLE);

   always_comb begin
      cmd          = '0;
      cmd.term_sel = TERM_VERTEX;
      case (state_ff)
         S_IDLE: begin
            cmd.accept    = req_valid;
            cmd.load_term = req_valid;
         end
         S_ACC: cmd.add_term = 1'b1;
         S_CLOSE: begin
            cmd.term_sel  = TERM_WRAP_FIRST;
            cmd.load_term = !short_ff && !stat.d_zero;
         end
         S_WRAP1: begin
            cmd.add_term  = 1'b1;
            cmd.term_sel  = TERM_WRAP_SECOND;
            cmd.load_term = 1'b1;
         end
         S_WRAP2: begin
            cmd.add_term   = 1'b1;
            cmd.start_root = 1'b1;
         end
         S_ROOT:  cmd.root_step = 1'b1;
         S_DIVST: cmd.start_div = 1'b1;
         S_DIV:   cmd.div_step = 1'b1;
         S_MULHI: cmd.mul_hi = 1'b1;
         S_MULLO: cmd.mul_lo = 1'b1;
         S_FIN:   cmd.finish = 1'b1;
         S_LOAD: begin
            cmd.load_out  = !rsp_valid_ff || rsp_ready;
            cmd.area_zero = (status_ff != STATUS_OK);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         step_ff       <= '0;
         last_ff       <= 1'b0;
         short_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         status_ff     <= STATUS_OK;
         rsp_status_ff <= STATUS_OK;
      end else begin
         if (cmd.load_out) begin
            rsp_valid_ff  <= 1'b1;
            rsp_status_ff <= status_ff;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  last_ff  <= req_last;
                  short_ff <= stat.tally_lt2;
                  if (!stat.tally_lt2) begin
                     state_ff <= S_ACC;
                  end else if (req_last) begin
                     state_ff <= S_CLOSE;
                  end
               end
            end
            S_ACC: state_ff <= last_ff ? S_CLOSE : S_IDLE;
            S_CLOSE: begin
               if (short_ff) begin
                  status_ff <= STATUS_SHORT;
                  state_ff  <= S_LOAD;
               end else if (stat.d_zero) begin
                  status_ff <= STATUS_ZERO_NORMAL;
                  state_ff  <= S_LOAD;
               end else begin
                  state_ff <= S_WRAP1;
               end
            end
            S_WRAP1: state_ff <= S_WRAP2;
            S_WRAP2: begin
               step_ff  <= '0;
               state_ff <= S_ROOT;
            end
            S_ROOT: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_W'(ITER_STEPS - 1)) begin
                  state_ff <= S_DIVST;
               end
            end
            S_DIVST: state_ff <= S_DIV;
            S_DIV: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_W'(ITER_STEPS - 1)) begin
                  state_ff <= S_MULHI;
               end
            end
            S_MULHI: state_ff <= S_MULLO;
            S_MULLO: state_ff <= S_FIN;
            S_FIN: begin
               status_ff <= STATUS_OK;
               state_ff  <= S_LOAD;
            end
            S_LOAD: begin
               if (cmd.load_out) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `ASSERT_NEXT(a_load_shows_result, cmd.load_out, rsp_valid_ff, "result not presented after load")
   `ASSERT_NEXT(a_short_status, state_ff == S_CLOSE && short_ff, status_ff == STATUS_SHORT,
      "short polygon did not get short status")
   `ASSERT_SAME(a_no_accept_when_busy, state_ff != S_IDLE, !cmd.accept,
      "vertex taken while closing")

endmodule

/* design/ppa_dp.sv */
// datapath: projection, shoelace sum, root, divide and scaling
module ppa_dp import ppa_pkg::*; #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [NORM_W-1:0]             csr_data,
   input  logic signed [COORD_WIDTH-1:0] vertex_x,
   input  logic signed [COORD_WIDTH-1:0] vertex_y,
   input  logic signed [COORD_WIDTH-1:0] vertex_z,
   input  logic                          last_vertex,
   input  ppa_cmd_type                   cmd,
   output ppa_stat_type                  stat,
   output logic [AREA_W-1:0]             area
);
`include "assert_macros.svh"

   localparam int CW = COORD_WIDTH;
   localparam int TW = 2 * CW + 1;
   localparam int EW = ((TW > SUM_W) ? TW : SUM_W) + 1;

   typedef enum logic [1:0] {AXIS_X, AXIS_Y, AXIS_Z} axis_type;

   logic signed [NORM_W-1:0] nx_ff, ny_ff, nz_ff;
   axis_type                 axis_ff;
   logic [1:0]               tally_ff;
   logic signed [CW-1:0]     open0_a_ff, open0_b_ff, open1_a_ff, open1_b_ff;
   logic signed [CW-1:0]     rec0_a_ff, rec0_b_ff, rec1_a_ff, rec1_b_ff;
   logic signed [TW-1:0]     term_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic [63:0]              rx_ff, rres_ff, rbit_ff;
   logic [31:0]              dq_ff;
   logic [NORM_W-1:0]        rem_ff;
   logic [63:0]              mag_ff, mhi_ff, mlo_ff;
   logic [AREA_W-1:0]        res_ff, area_ff;

   logic [NORM_W-1:0]        ax, ay, az, d;
   axis_type                 axis_new, axis_now;
   logic signed [CW-1:0]     p_a, p_b, mid, nb, pb;
   logic signed [CW:0]       diff;
   logic signed [TW-1:0]     term_in;
   logic signed [EW-1:0]     sum_x;
   logic signed [SUM_W-1:0]  sum_in;
   logic signed [2*NORM_W-1:0] sqx, sqy, sqz;
   logic [31:0]              q;
   logic [63:0]              rtrial;
   logic [NORM_W:0]          dtrial;
   logic [63:0]              mul_out, r64, mag;

   assign ax = nx_ff[NORM_W-1] ? NORM_W'(-nx_ff) : nx_ff;
   assign ay = ny_ff[NORM_W-1] ? NORM_W'(-ny_ff) : ny_ff;
   assign az = nz_ff[NORM_W-1] ? NORM_W'(-nz_ff) : nz_ff;

   always_comb begin
      if (ax > ay) begin
         axis_new = (ax > az) ? AXIS_X : AXIS_Z;
      end else begin
         axis_new = (ay > az) ? AXIS_Y : AXIS_Z;
      end
      axis_now = (tally_ff == 2'd0) ? axis_new : axis_ff;
      case (axis_ff)
         AXIS_X:  d = ax;
         AXIS_Y:  d = ay;
         default: d = az;
      endcase
      case (axis_now)
         AXIS_X: begin
            p_a = vertex_y;
            p_b = vertex_z;
         end
         AXIS_Y: begin
            p_a = vertex_z;
            p_b = vertex_x;
         end
         default: begin
            p_a = vertex_x;
            p_b = vertex_y;
         end
      endcase
   end

   assign stat.tally_lt2 = (tally_ff < 2'd2);
   assign stat.d_zero    = (d == '0);

   // term = mid.a * (next.b - prev.b)
   always_comb begin
      case (cmd.term_sel)
         TERM_WRAP_FIRST: begin
            mid = rec1_a_ff;
            nb  = open0_b_ff;
            pb  = rec0_b_ff;
         end
         TERM_WRAP_SECOND: begin
            mid = open0_a_ff;
            nb  = open1_b_ff;
            pb  = rec1_b_ff;
         end
         default: begin
            mid = rec1_a_ff;
            nb  = p_b;
            pb  = rec0_b_ff;
         end
      endcase
      diff    = (CW + 1)'(nb) - (CW + 1)'(pb);
      term_in = TW'(mid) * TW'(diff);
   end

   // saturating add into the 64-bit sum
   always_comb begin
      sum_x = EW'(sum_ff) + EW'(term_ff);
      if (&sum_x[EW-1:SUM_W-1] || ~|sum_x[EW-1:SUM_W-1]) begin
         sum_in = sum_x[SUM_W-1:0];
      end else if (sum_x[EW-1]) begin
         sum_in = {1'b1, {(SUM_W - 1){1'b0}}};
      end else begin
         sum_in = {1'b0, {(SUM_W - 1){1'b1}}};
      end
   end

   assign sqx = nx_ff * nx_ff;
   assign sqy = ny_ff * ny_ff;
   assign sqz = nz_ff * nz_ff;
   assign q   = 32'(sqx) + 32'(sqy) + 32'(sqz);

   assign rtrial  = rres_ff + rbit_ff;
   assign dtrial  = {rem_ff, dq_ff[31]};
   assign mag     = sum_ff[SUM_W-1] ? 64'(-sum_ff) : 64'(sum_ff);
   assign mul_out = (cmd.mul_hi ? mag_ff[63:32] : mag_ff[31:0]) * dq_ff;
   assign r64     = {mhi_ff[48:0], 15'b0} + {17'b0, mlo_ff[63:17]};

   always_ff @(posedge clock) begin
      if (reset) begin
         nx_ff    <= '0;
         ny_ff    <= '0;
         nz_ff    <= 16'sd16384;
         axis_ff  <= AXIS_Z;
         tally_ff <= '0;
         sum_ff   <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_NORMAL_X: nx_ff <= csr_data;
               CSR_NORMAL_Y: ny_ff <= csr_data;
               CSR_NORMAL_Z: nz_ff <= csr_data;
               default: ;
            endcase
         end
         if (cmd.accept) begin
            axis_ff <= axis_now;
            if (last_vertex) begin
               tally_ff <= '0;
            end else if (tally_ff != 2'd3) begin
               tally_ff <= tally_ff + 1'b1;
            end
         end
         if (cmd.add_term) begin
            sum_ff <= sum_in;
         end else if (cmd.load_out) begin
            sum_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         if (tally_ff == 2'd0) begin
            open0_a_ff <= p_a;
            open0_b_ff <= p_b;
         end
         if (tally_ff == 2'd1) begin
            open1_a_ff <= p_a;
            open1_b_ff <= p_b;
         end
         rec0_a_ff <= rec1_a_ff;
         rec0_b_ff <= rec1_b_ff;
         rec1_a_ff <= p_a;
         rec1_b_ff <= p_b;
      end
      if (cmd.load_term) begin
         term_ff <= term_in;
      end
      // bit-pair integer square root of q << 32
      if (cmd.start_root) begin
         rx_ff   <= {q, 32'b0};
         rres_ff <= '0;
         rbit_ff <= 64'h4000_0000_0000_0000;
      end else if (cmd.root_step) begin
         if (rx_ff >= rtrial) begin
            rx_ff   <= rx_ff - rtrial;
            rres_ff <= (rres_ff >> 1) + rbit_ff;
         end else begin
            rres_ff <= rres_ff >> 1;
         end
         rbit_ff <= rbit_ff >> 2;
      end
      // restoring divide of the root by the dropped normal component
      if (cmd.start_div) begin
         dq_ff  <= rres_ff[31:0];
         rem_ff <= '0;
         mag_ff <= mag;
      end else if (cmd.div_step) begin
         if (dtrial >= {1'b0, d}) begin
            rem_ff <= NORM_W'(dtrial - {1'b0, d});
            dq_ff  <= {dq_ff[30:0], 1'b1};
         end else begin
            rem_ff <= dtrial[NORM_W-1:0];
            dq_ff  <= {dq_ff[30:0], 1'b0};
         end
      end
      if (cmd.mul_hi) begin
         mhi_ff <= mul_out;
      end
      if (cmd.mul_lo) begin
         mlo_ff <= mul_out;
      end
      if (cmd.finish) begin
         res_ff <= (r64[63:AREA_W] != '0) ? '1 : r64[AREA_W-1:0];
      end
      if (cmd.load_out) begin
         area_ff <= cmd.area_zero ? '0 : res_ff;
      end
   end

   assign area = area_ff;

   `ASSERT_NEXT(a_tally_clears, cmd.accept && last_vertex, tally_ff == 2'd0,
      "vertex count not cleared after closing vertex")
   `ASSERT_SAME(a_div_nonzero, cmd.div_step || cmd.start_div, !stat.d_zero,
      "divide started with zero divisor")
   `ASSERT_NEXT(a_sum_clears, cmd.load_out, sum_ff == '0,
      "sum not cleared after result load")

endmodule

/* design/planar_polygon_area_3d.sv */
// A vertex is taken in S_IDLE, and also passes through S_ACC (term add) once two vertices are already held.
// A closing vertex then runs the wrap terms, 32 square root steps, 32 divide steps
// and two 32x32 multiplies, all through one shared datapath.
// One polygon is closed at a time; no vertex is taken until its result is loaded.
// Synchronous active-high reset clears the normal to (0, 0, 16384) and the sum.
module planar_polygon_area_3d import ppa_pkg::*; #(
   parameter int COORD_WIDTH = 24
) (
   input logic       clock,
   input logic       reset,
   ppa_vertex_if.sink req,
   ppa_area_if.source rsp,
   ppa_csr_if.sink   csr
);

   ppa_cmd_type  cmd;
   ppa_stat_type stat;
   status_type   status;

   assign csr.ready  = 1'b1;
   assign rsp.status = status;

   ppa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_last   (req.last_vertex),
      .req_ready  (req.ready),
      .rsp_ready  (rsp.ready),
      .rsp_valid  (rsp.valid),
      .rsp_status (status),
      .cmd        (cmd),
      .stat       (stat)
   );

   ppa_dp #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr.valid),
      .csr_index   (csr.index),
      .csr_data    (csr.data),
      .vertex_x    (req.vertex_x),
      .vertex_y    (req.vertex_y),
      .vertex_z    (req.vertex_z),
      .last_vertex (req.last_vertex),
      .cmd         (cmd),
      .stat        (stat),
      .area        (rsp.area)
   );

endmodule

/* tb/planar_polygon_area_3d_tb.sv */
// self-checking testbench for planar_polygon_area_3d with a built-in area predictor
module planar_polygon_area_3d_tb;
   import ppa_pkg::*;

   localparam int CW          = 24;
   localparam int DRAIN_WAIT  = 120;
   localparam int CYCLE_LIMIT = 2000000;
   localparam logic [AREA_W-1:0] AREA_SAT = {AREA_W{1'b1}};
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
      logic                 last;
   } vertex_type;

   typedef struct {
      logic [AREA_W-1:0] area;
      status_type        status;
   } area_result_type;

   logic clock;
   logic reset;

   ppa_vertex_if #(.COORD_WIDTH(CW)) req_if ();
   ppa_area_if                       rsp_if ();
   ppa_csr_if                        csr_if ();

   planar_polygon_area_3d #(.COORD_WIDTH(CW)) u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   vertex_type      vertex_q[$];
   area_result_type area_q[$];

   // predictor state
   logic signed [NORM_W-1:0] norm_x, norm_y, norm_z;
   longint                   open_a[2], open_b[2], recent_a[2], recent_b[2];
   longint                   shoelace;
   int                       tally;
   int                       axis;

   int  send_idle, recv_idle, recv_hold;
   bit  req_fire;
   int  cycles, errors, polygons, results, n_short, n_zero, n_sat;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic longint sat_sum(longint a, longint b);
      longint s;
      s = a + b;
      if (b > 0 && s < a) return 64'sh7fffffffffffffff;
      if (b < 0 && s > a) return 64'sh8000000000000000;
      return s;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root, bit_val;
      root    = 0;
      bit_val = 64'h1 << 62;
      while (bit_val > v) bit_val >>= 2;
      while (bit_val != 0) begin
         if (v >= root + bit_val) begin
            v    = v - (root + bit_val);
            root = (root >> 1) + bit_val;
         end else begin
            root >>= 1;
         end
         bit_val >>= 2;
      end
      return root;
   endfunction

   function automatic longint unsigned mag64(longint v);
      return v < 0 ? 64'd0 - longint'(v) : v;
   endfunction

   // update the polygon state with one vertex; on closing queue the expected area
   task automatic predict_area(vertex_type v);
      longint nx, ny, nz, pa, pb, s, nd;
      longint unsigned ax, ay, az, d, q, ratio, m, r;
      area_result_type exp_r;
      nx = norm_x; ny = norm_y; nz = norm_z;
      if (tally == 0) begin
         ax = mag64(nx); ay = mag64(ny); az = mag64(nz);
         axis = 2;
         if (ax > ay) begin
            if (ax > az) axis = 0;
         end else if (ay > az) begin
            axis = 1;
         end
      end
      case (axis)
         0: begin pa = v.y; pb = v.z; end
         1: begin pa = v.z; pb = v.x; end
         default: begin pa = v.x; pb = v.y; end
      endcase
      if (tally == 0) begin
         open_a[0] = pa; open_b[0] = pb;
      end else if (tally == 1) begin
         open_a[1] = pa; open_b[1] = pb;
      end else begin
         shoelace = sat_sum(shoelace, recent_a[1] * (pb - recent_b[0]));
      end
      recent_a[0] = recent_a[1]; recent_b[0] = recent_b[1];
      recent_a[1] = pa;          recent_b[1] = pb;
      if (tally < 3) tally++;
      if (!v.last) return;
      exp_r.area   = '0;
      exp_r.status = STATUS_OK;
      if (tally < 3) begin
         exp_r.status = STATUS_SHORT;
      end else begin
         nd = (axis == 0) ? nx : ((axis == 1) ? ny : nz);
         d  = mag64(nd);
         if (d == 0) begin
            exp_r.status = STATUS_ZERO_NORMAL;
         end else begin
            s = sat_sum(shoelace, recent_a[1] * (open_b[0] - recent_b[0]));
            s = sat_sum(s, open_a[0] * (open_b[1] - recent_b[1]));
            q = nx * nx + ny * ny + nz * nz;
            ratio = int_sqrt(q << 32) / d;
            m = mag64(s);
            r = (((m >> 32) * ratio) << 15) + (((m & 64'hffffffff) * ratio) >> 17);
            exp_r.area = (r > AREA_SAT) ? AREA_SAT : r[AREA_W-1:0];
         end
      end
      area_q.insert(area_q.size(), exp_r);
      shoelace = 0;
      tally    = 0;
   endtask

   // monitor: predictor update on every transaction, result check on rsp
   always @(posedge clock) begin
      area_result_type exp_r;
      req_fire <= req_if.valid && req_if.ready;
      if (!reset) begin
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               CSR_NORMAL_X: norm_x = csr_if.data;
               CSR_NORMAL_Y: norm_y = csr_if.data;
               CSR_NORMAL_Z: norm_z = csr_if.data;
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready)
            predict_area('{req_if.vertex_x, req_if.vertex_y, req_if.vertex_z,
                           req_if.last_vertex});
         if (rsp_if.valid && rsp_if.ready) begin
            results++;
            if (area_q.size() == 0) begin
               $error("area transaction with no expected result");
               errors++;
            end else begin
               exp_r = area_q.pop_front();
               if (rsp_if.area !== exp_r.area) begin
                  $error("area: expected %0d, actual %0d", exp_r.area, rsp_if.area);
                  errors++;
               end
               if (rsp_if.status !== exp_r.status) begin
                  $error("status: expected %0d, actual %0d", exp_r.status, rsp_if.status);
                  errors++;
               end
               if (exp_r.status == STATUS_SHORT) n_short++;
               if (exp_r.status == STATUS_ZERO_NORMAL) n_zero++;
               if (exp_r.area == AREA_SAT) n_sat++;
            end
         end
      end
   end

   // vertex driver
   always @(negedge clock) begin
      vertex_type v;
      if (!reset && (!req_if.valid || req_fire)) begin
         if (vertex_q.size() != 0 && $urandom_range(99) >= send_idle) begin
            v = vertex_q.pop_front();
            req_if.valid       <= 1'b1;
            req_if.vertex_x    <= v.x;
            req_if.vertex_y    <= v.y;
            req_if.vertex_z    <= v.z;
            req_if.last_vertex <= v.last;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // result receiver with optional long hold-off
   always @(negedge clock) begin
      if (recv_hold > 0) begin
         recv_hold     <= recv_hold - 1;
         rsp_if.ready  <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("planar_polygon_area_3d_tb: done, errors");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [NORM_W-1:0] val);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= val;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic set_normal(logic [15:0] nx, logic [15:0] ny, logic [15:0] nz);
      write_reg(CSR_NORMAL_X, nx);
      write_reg(CSR_NORMAL_Y, ny);
      write_reg(CSR_NORMAL_Z, nz);
   endtask

   task automatic add_vertex(int x, int y, int z, bit last);
      vertex_type v;
      v.x = CW'(x); v.y = CW'(y); v.z = CW'(z); v.last = last;
      vertex_q.insert(vertex_q.size(), v);
      if (last) polygons++;
   endtask

   function automatic int rand_coord(int span);
      if (span <= 0) return int'(signed'($urandom_range(24'hffffff) << 8)) >>> 8;
      return int'($urandom_range(2 * span)) - span;
   endfunction

   task automatic add_polygon(int n, int span);
      for (int i = 0; i < n; i++)
         add_vertex(rand_coord(span), rand_coord(span), rand_coord(span), i == n - 1);
   endtask

   task automatic wait_drained();
      while (vertex_q.size() != 0 || req_if.valid || area_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic random_phase(int n_vertices);
      int sent, n, span;
      sent = 0;
      while (sent < n_vertices) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 9);
         case ($urandom_range(3))
            0: span = 0;
            1: span = 255;
            2: span = 40000;
            default: span = $urandom_range(1, 8388607);
         endcase
         add_polygon(n, span);
         sent += n;
      end
   endtask

   localparam int N_SETS = 9;
   logic [15:0] normal_set[N_SETS][3] = '{
      '{16'h0000, 16'h0000, 16'h4000},
      '{16'h7fff, 16'h0000, 16'h0000},
      '{16'h0000, 16'h8000, 16'h0000},
      '{16'h8000, 16'h8000, 16'h8000},
      '{16'h0000, 16'h0000, 16'h0000},
      '{16'h0005, 16'h0001, 16'hfffd},
      '{16'h0001, 16'h7fff, 16'h8001},
      '{16'h7fff, 16'h8000, 16'h0001},
      '{16'hc000, 16'h2000, 16'h1234}
   };

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.vertex_x = '0; req_if.vertex_y = '0; req_if.vertex_z = '0;
      req_if.last_vertex = 1'b0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0; csr_if.index = '0; csr_if.data = '0;
      norm_x = 16'sd0; norm_y = 16'sd0; norm_z = 16'sd16384;
      shoelace = 0; tally = 0; axis = 2;
      foreach (open_a[i]) begin
         open_a[i] = 0; open_b[i] = 0; recent_a[i] = 0; recent_b[i] = 0;
      end
      send_idle = 0; recv_idle = 0; recv_hold = 0;
      cycles = 0; errors = 0; polygons = 0; results = 0;
      n_short = 0; n_zero = 0; n_sat = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset normal, extreme coordinates, short polygons
      add_vertex(8388607, -8388608, 8388607, 0);
      add_vertex(-8388608, 8388607, -8388608, 0);
      add_vertex(8388607, 8388607, 0, 1);
      add_vertex(5, 6, 7, 1);
      add_vertex(1, 1, 1, 0);
      add_vertex(-1, -1, -1, 1);
      add_vertex(0, 0, 0, 0);
      add_vertex(256, 0, 0, 0);
      add_vertex(256, 256, 0, 0);
      add_vertex(0, 256, 0, 1);
      wait_drained();
      // large normal with the y component dropped, huge triangle
      set_normal(16'h7fff, 16'h8000, 16'h0001);
      add_vertex(0, 0, 0, 0);
      add_vertex(-8388608, 8388607, 0, 0);
      add_vertex(8388607, -8388608, 8388607, 1);
      wait_drained();
      // mid-polygon change makes the latched component zero
      set_normal(16'h0000, 16'h0000, 16'h4000);
      add_vertex(100, 200, 300, 0);
      add_vertex(-400, 500, 600, 0);
      wait_drained();
      write_reg(CSR_NORMAL_Z, 16'h0000);
      write_reg(CSR_NORMAL_X, 16'h0010);
      add_vertex(700, -800, 900, 1);
      wait_drained();
      // all-zero normal
      set_normal(16'h0000, 16'h0000, 16'h0000);
      add_polygon(4, 1000);
      wait_drained();
      write_reg(CSR_UNUSED, 16'hffff);

      // random phases across normal settings and idling regimes
      for (int p = 0; p < N_SETS * 2; p++) begin
         if (p < 6) begin
            send_idle = 19; recv_idle = 79;
         end else if (p < 12) begin
            send_idle = 79; recv_idle = 19;
         end else begin
            send_idle = 0; recv_idle = 0;
         end
         set_normal(normal_set[p % N_SETS][0], normal_set[p % N_SETS][1],
                    normal_set[p % N_SETS][2]);
         if (p == 13) recv_hold = 400;
         random_phase(68);
         wait_drained();
      end

      $display("covered %0d polygons, %0d results checked", polygons, results);
      $display("short %0d, zero normal %0d, saturated %0d", n_short, n_zero, n_sat);
      if (errors == 0) begin
         $display("planar_polygon_area_3d_tb: done, clean");
      end else begin
         $display("planar_polygon_area_3d_tb: done, errors");
      end
      $finish;
   end

endmodule
